// File: rtl/buddy_block_allocator_macros.svh
// ----------------------------------------------------------------------------
// Buddy block allocator assertion macros
// Shorthand for clocked implication checks used inside the RTL datapath module.
// ----------------------------------------------------------------------------
`ifndef BUDDY_BLOCK_ALLOCATOR_MACROS_SVH
`define BUDDY_BLOCK_ALLOCATOR_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define BBA_ASSERT_NOW(lbl, pre, post, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (pre) |-> (post)) \
      else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define BBA_ASSERT_NEXT(lbl, pre, post, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (pre) |=> (post)) \
      else $error(msg);

`endif

// File: rtl/bba_pkg.sv
// ----------------------------------------------------------------------------
// Buddy block allocator package
// Shared widths, codes, payload types and controller/datapath interfaces.
// ----------------------------------------------------------------------------
package bba_pkg;

   localparam int NUM_BLOCKS = 1024;
   localparam int IDX_W      = 10;
   localparam int LINK_W     = 11;
   localparam int MAX_LOG    = 10;
   localparam int LOG_W      = 4;
   localparam int REQ_W      = 31;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 11;
   localparam int CTRL_W     = 6;

   localparam logic [LINK_W-1:0] NIL         = '1;
   localparam logic [REQ_W-1:0]  BIG_REQUEST = 31'h4000_0000;
   localparam logic [LOG_W-1:0]  ATOM_LOG_MIN = 4'd3;
   localparam logic [LOG_W-1:0]  ATOM_LOG_MAX = 4'd12;

   // Actions
   localparam logic [1:0] ACT_ALLOC   = 2'd0;
   localparam logic [1:0] ACT_FREE    = 2'd1;
   localparam logic [1:0] ACT_REBUILD = 2'd2;

   // Status codes
   localparam logic [1:0] ST_OK       = 2'd0;
   localparam logic [1:0] ST_NOSPACE  = 2'd1;
   localparam logic [1:0] ST_BADREQ   = 2'd2;
   localparam logic [1:0] ST_BADFREE  = 2'd3;

   // Configuration register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_POOL_BLOCKS = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_ATOM_LOG    = 2'd1;

   typedef struct packed {
      logic [1:0]       action;
      logic [REQ_W-1:0] request_bytes;
      logic [IDX_W-1:0] free_index;
   } req_type;

   typedef struct packed {
      logic [1:0]       status;
      logic [IDX_W-1:0] granted_index;
      logic [LOG_W-1:0] granted_log;
   } rsp_type;

   typedef enum logic [3:0] {
      S_IDLE, S_ALOG, S_ABIN, S_RMRD, S_RMWR, S_SPLIT, S_FRD, S_FCHK,
      S_MRD, S_MCHK, S_PUSH1, S_PUSH2, S_CLR, S_CARVE, S_DONE
   } state_type;

   typedef enum logic [4:0] {
      CMD_NONE, CMD_LOAD, CMD_ALOG, CMD_ABIN, CMD_RMRD, CMD_RMWR, CMD_SPLIT,
      CMD_AFIN, CMD_FRD, CMD_FCHK, CMD_MRD, CMD_MCHK, CMD_PUSH1, CMD_PUSH2,
      CMD_CLR, CMD_CARVE, CMD_FIN
   } cmd_type;

   typedef struct packed {
      cmd_type    op;
      logic [1:0] st;
      logic       keep;
   } dp_cmd_type;

   typedef struct packed {
      logic req_bad;
      logic lg_big;
      logic bin_found;
      logic split_done;
      logic range_bad;
      logic free_bad;
      logic merge_stop;
      logic merge_match;
      logic clr_last;
      logic carve_last;
      logic out_free;
   } dp_stat_type;

endpackage

// File: rtl/buddy_block_allocator.sv
// Allocate splits one level per step; free reads and checks the buddy at each merge level;
// rebuild clears all 1024 control entries, then carves in 11 steps (classes 10 down to 0).
// Throughput: one item at a time; the next is taken the cycle after the result is registered,
// later while an earlier result still waits for the receiver.
// Reset: synchronous; lists empty, pool of zero atoms until the first rebuild.
// ----------------------------------------------------------------------------
// Buddy block allocator
// Power-of-two block allocator over a pool of atoms with per-class free lists.
// ----------------------------------------------------------------------------
module buddy_block_allocator (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  bba_pkg::req_type                  req_payload,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output bba_pkg::rsp_type                  rsp_payload,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [bba_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [bba_pkg::CSR_DATA_W-1:0]    csr_data
);
   import bba_pkg::*;

   dp_cmd_type  cmd;
   dp_stat_type stat;

   // Register writes are always taken.
   assign csr_ready = 1'b1;

   // Sequencer.
   bba_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_action (req_payload.action),
      .stat       (stat),
      .cmd        (cmd)
   );

   // Storage and arithmetic.
   bba_dpath u_dpath (
      .clock       (clock),
      .reset       (reset),
      .req_payload (req_payload),
      .csr_valid   (csr_valid),
      .csr_index   (csr_index),
      .csr_data    (csr_data),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload),
      .cmd         (cmd),
      .stat        (stat)
   );

endmodule

// File: rtl/bba_ctrl.sv
// ----------------------------------------------------------------------------
// Buddy block allocator controller
// Sequences allocate, free and rebuild through the datapath commands.
// ----------------------------------------------------------------------------
module bba_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  logic [1:0]          req_action,
   input  bba_pkg::dp_stat_type stat,
   output bba_pkg::dp_cmd_type  cmd
);
   import bba_pkg::*;

   state_type  state_ff, state_in;
   logic [1:0] op_ff, op_in;
   logic [1:0] st_ff, st_in;

   // State and result code registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
      op_ff <= op_in;
      st_ff <= st_in;
   end

   // Next state.
   always_comb begin
      state_in = state_ff;
      op_in    = op_ff;
      st_in    = st_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               op_in = req_action;
               priority if (req_action == ACT_ALLOC) state_in = S_ALOG;
               else if (req_action == ACT_FREE)      state_in = S_FRD;
               else if (req_action == ACT_REBUILD)   state_in = S_CLR;
               else                                  state_in = S_IDLE;
            end
         end
         S_ALOG: begin
            priority if (stat.req_bad) begin
               st_in = ST_BADREQ; state_in = S_DONE;
            end else if (stat.lg_big) begin
               st_in = ST_NOSPACE; state_in = S_DONE;
            end else begin
               state_in = S_ABIN;
            end
         end
         S_ABIN: begin
            if (stat.bin_found) begin
               state_in = S_RMRD;
            end else begin
               st_in = ST_NOSPACE; state_in = S_DONE;
            end
         end
         S_RMRD:  state_in = S_RMWR;
         S_RMWR:  state_in = S_SPLIT;
         S_SPLIT: begin
            if (stat.split_done) begin
               st_in = ST_OK; state_in = S_DONE;
            end
         end
         S_FRD: begin
            if (stat.range_bad) begin
               st_in = ST_BADFREE; state_in = S_DONE;
            end else begin
               state_in = S_FCHK;
            end
         end
         S_FCHK: begin
            if (stat.free_bad) begin
               st_in = ST_BADFREE; state_in = S_DONE;
            end else begin
               state_in = S_MRD;
            end
         end
         S_MRD:   state_in = stat.merge_stop ? S_PUSH1 : S_MCHK;
         S_MCHK:  state_in = stat.merge_match ? S_MRD : S_PUSH1;
         S_PUSH1: state_in = S_PUSH2;
         S_PUSH2: begin
            st_in = ST_OK; state_in = S_DONE;
         end
         S_CLR:   if (stat.clr_last) state_in = S_CARVE;
         S_CARVE: begin
            if (stat.carve_last) begin
               st_in = ST_OK; state_in = S_DONE;
            end
         end
         S_DONE:  if (stat.out_free) state_in = S_IDLE;
      endcase
   end

   // Outputs.
   always_comb begin
      req_ready = (state_ff == S_IDLE);
      cmd.st    = st_ff;
      cmd.keep  = (op_ff != ACT_REBUILD);
      cmd.op    = CMD_NONE;
      unique case (state_ff)
         S_IDLE:  cmd.op = req_valid ? CMD_LOAD : CMD_NONE;
         S_ALOG:  cmd.op = CMD_ALOG;
         S_ABIN:  cmd.op = CMD_ABIN;
         S_RMRD:  cmd.op = CMD_RMRD;
         S_RMWR:  cmd.op = CMD_RMWR;
         S_SPLIT: cmd.op = stat.split_done ? CMD_AFIN : CMD_SPLIT;
         S_FRD:   cmd.op = CMD_FRD;
         S_FCHK:  cmd.op = CMD_FCHK;
         S_MRD:   cmd.op = CMD_MRD;
         S_MCHK:  cmd.op = CMD_MCHK;
         S_PUSH1: cmd.op = CMD_PUSH1;
         S_PUSH2: cmd.op = CMD_PUSH2;
         S_CLR:   cmd.op = CMD_CLR;
         S_CARVE: cmd.op = CMD_CARVE;
         S_DONE:  cmd.op = stat.out_free ? CMD_FIN : CMD_NONE;
      endcase
   end

endmodule

// File: rtl/bba_dpath.sv
// ----------------------------------------------------------------------------
// Buddy block allocator datapath
// Control and link memories, list heads, configuration and result register.
// ----------------------------------------------------------------------------
`include "buddy_block_allocator_macros.svh"

module bba_dpath (
   input  logic                              clock,
   input  logic                              reset,
   input  bba_pkg::req_type                  req_payload,
   input  logic                              csr_valid,
   input  logic [bba_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [bba_pkg::CSR_DATA_W-1:0]    csr_data,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output bba_pkg::rsp_type                  rsp_payload,
   input  bba_pkg::dp_cmd_type               cmd,
   output bba_pkg::dp_stat_type              stat
);
   import bba_pkg::*;

   // Memories and their registered read data.
   logic [CTRL_W-1:0] ctrl_mem_ff [NUM_BLOCKS];
   logic [LINK_W-1:0] next_mem_ff [NUM_BLOCKS];
   logic [LINK_W-1:0] prev_mem_ff [NUM_BLOCKS];
   logic [CTRL_W-1:0] ctrl_q_ff;
   logic [LINK_W-1:0] next_q_ff, prev_q_ff;

   logic [LINK_W-1:0] heads_ff [MAX_LOG+1];

   logic [LINK_W-1:0] pool_ff, built_n_ff;
   logic [LOG_W-1:0]  alog_ff, built_a_ff;
   logic [REQ_W-1:0]  req_ff, dec_ff;
   logic [IDX_W-1:0]  idx_ff, clr_cnt_ff;
   logic [LOG_W-1:0]  lg_ff, bin_ff, rm_lg_ff;
   logic [LINK_W-1:0] off_ff;
   logic              rsp_valid_ff;
   rsp_type           rsp_ff;

   logic [4:0]        k_bits, lg_calc;
   logic              found;
   logic [LOG_W-1:0]  bin_sel;
   logic [LINK_W-1:0] blk_ext, size_m, bud;
   logic              upper;
   logic [LOG_W-1:0]  fl;
   logic [11:0]       fsize;
   logic [LOG_W-1:0]  split_b;
   logic [IDX_W-1:0]  half;
   logic [LINK_W-1:0] carve_sz;
   logic              carve_fits;
   logic              rm_en;
   logic [IDX_W-1:0]  rd_addr;
   logic              ctrl_we, next_we, prev_we;
   logic [IDX_W-1:0]  ctrl_wa, next_wa, prev_wa;
   logic [CTRL_W-1:0] ctrl_wd;
   logic [LINK_W-1:0] next_wd, prev_wd;
   logic [LINK_W-1:0] first;
   logic              keep;

   // Rounded size class: bit length of request minus one, less the atom log.
   always_comb begin
      k_bits = '0;
      for (int j = 0; j < REQ_W; j++) begin
         if (dec_ff[j]) k_bits = 5'(j + 1);
      end
      lg_calc = (k_bits > {1'b0, built_a_ff}) ? k_bits - {1'b0, built_a_ff} : '0;
   end

   // Smallest nonempty class at or above the wanted one.
   always_comb begin
      found   = 1'b0;
      bin_sel = '0;
      for (int b = MAX_LOG; b >= 0; b--) begin
         if (LOG_W'(b) >= lg_ff && !heads_ff[b][LINK_W-1]) begin
            found   = 1'b1;
            bin_sel = LOG_W'(b);
         end
      end
   end

   // Buddy of the block being merged.
   always_comb begin
      blk_ext = {1'b0, idx_ff};
      size_m  = LINK_W'(1) << lg_ff;
      upper   = ((blk_ext >> lg_ff) & LINK_W'(1)) != '0;
      bud     = upper ? blk_ext - size_m : blk_ext + size_m;
   end

   // Split, carve and free-check helpers.
   always_comb begin
      fl         = ctrl_q_ff[LOG_W-1:0];
      fsize      = 12'(1) << fl;
      split_b    = bin_ff - LOG_W'(1);
      half       = idx_ff + (IDX_W'(1) << split_b);
      carve_sz   = LINK_W'(1) << bin_ff;
      carve_fits = ({1'b0, off_ff} + {1'b0, carve_sz}) <= {1'b0, built_n_ff};
      first      = heads_ff[lg_ff];
      rd_addr    = (cmd.op == CMD_MRD) ? bud[IDX_W-1:0] : idx_ff;
   end

   // Status to the controller.
   always_comb begin
      stat.req_bad     = (req_ff == '0) || (req_ff > BIG_REQUEST);
      stat.lg_big      = lg_calc > 5'(MAX_LOG);
      stat.bin_found   = found;
      stat.split_done  = (bin_ff == lg_ff);
      stat.range_bad   = {1'b0, idx_ff} >= built_n_ff;
      stat.free_bad    = !ctrl_q_ff[5] || ctrl_q_ff[4] || (fl > LOG_W'(MAX_LOG))
                         || ((12'(idx_ff) & (fsize - 12'd1)) != '0)
                         || ((12'(idx_ff) + fsize) > 12'(built_n_ff));
      stat.merge_stop  = (lg_ff >= LOG_W'(MAX_LOG)) || (!upper && bud >= built_n_ff);
      stat.merge_match = (ctrl_q_ff == {2'b11, lg_ff});
      stat.clr_last    = (clr_cnt_ff == IDX_W'(NUM_BLOCKS - 1));
      stat.carve_last  = (bin_ff == '0);
      stat.out_free    = !rsp_valid_ff || rsp_ready;
   end

   assign rm_en = (cmd.op == CMD_RMWR) || (cmd.op == CMD_MCHK && stat.merge_match);

   // Memory write selection; each memory takes at most one write per cycle.
   always_comb begin
      ctrl_we = 1'b0; ctrl_wa = idx_ff; ctrl_wd = '0;
      next_we = 1'b0; next_wa = idx_ff; next_wd = NIL;
      prev_we = 1'b0; prev_wa = idx_ff; prev_wd = NIL;
      if (rm_en) begin
         next_we = !prev_q_ff[LINK_W-1];
         next_wa = prev_q_ff[IDX_W-1:0];
         next_wd = next_q_ff;
         prev_we = !next_q_ff[LINK_W-1];
         prev_wa = next_q_ff[IDX_W-1:0];
         prev_wd = prev_q_ff;
      end
      unique case (cmd.op)
         CMD_MCHK: begin
            ctrl_we = stat.merge_match;
            ctrl_wa = upper ? idx_ff : bud[IDX_W-1:0];
            ctrl_wd = '0;
         end
         CMD_SPLIT: begin
            ctrl_we = 1'b1; ctrl_wa = half; ctrl_wd = {2'b11, split_b};
            next_we = 1'b1; next_wa = half; next_wd = NIL;
            prev_we = 1'b1; prev_wa = half; prev_wd = NIL;
         end
         CMD_AFIN: begin
            ctrl_we = 1'b1; ctrl_wa = idx_ff; ctrl_wd = {2'b10, lg_ff};
         end
         CMD_PUSH1: begin
            ctrl_we = 1'b1; ctrl_wa = idx_ff; ctrl_wd = {2'b11, lg_ff};
            next_we = 1'b1; next_wa = idx_ff; next_wd = first;
            prev_we = !first[LINK_W-1];
            prev_wa = first[IDX_W-1:0];
            prev_wd = {1'b0, idx_ff};
         end
         CMD_PUSH2: begin
            prev_we = 1'b1; prev_wa = idx_ff; prev_wd = NIL;
         end
         CMD_CLR: begin
            ctrl_we = 1'b1; ctrl_wa = clr_cnt_ff; ctrl_wd = '0;
         end
         CMD_CARVE: begin
            ctrl_we = carve_fits; ctrl_wa = off_ff[IDX_W-1:0]; ctrl_wd = {2'b11, bin_ff};
            next_we = carve_fits; next_wa = off_ff[IDX_W-1:0]; next_wd = NIL;
            prev_we = carve_fits; prev_wa = off_ff[IDX_W-1:0]; prev_wd = NIL;
         end
         default: ;
      endcase
   end

   // Control memory.
   always_ff @(posedge clock) begin
      if (ctrl_we) ctrl_mem_ff[ctrl_wa] <= ctrl_wd;
      ctrl_q_ff <= ctrl_mem_ff[rd_addr];
   end

   // Next-link memory.
   always_ff @(posedge clock) begin
      if (next_we) next_mem_ff[next_wa] <= next_wd;
      next_q_ff <= next_mem_ff[rd_addr];
   end

   // Previous-link memory.
   always_ff @(posedge clock) begin
      if (prev_we) prev_mem_ff[prev_wa] <= prev_wd;
      prev_q_ff <= prev_mem_ff[rd_addr];
   end

   // List heads.
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int h = 0; h <= MAX_LOG; h++) heads_ff[h] <= NIL;
      end else begin
         unique case (cmd.op)
            CMD_RMWR: if (prev_q_ff[LINK_W-1]) heads_ff[rm_lg_ff] <= next_q_ff;
            CMD_MCHK: begin
               if (stat.merge_match && prev_q_ff[LINK_W-1]) heads_ff[rm_lg_ff] <= next_q_ff;
            end
            CMD_SPLIT: heads_ff[split_b] <= {1'b0, half};
            CMD_PUSH1: heads_ff[lg_ff] <= {1'b0, idx_ff};
            CMD_CARVE: heads_ff[bin_ff] <= carve_fits ? {1'b0, off_ff[IDX_W-1:0]} : NIL;
            default: ;
         endcase
      end
   end

   // Configuration registers and the pool taken at rebuild.
   always_ff @(posedge clock) begin
      if (reset) begin
         pool_ff    <= LINK_W'(NUM_BLOCKS);
         alog_ff    <= ATOM_LOG_MIN;
         built_n_ff <= '0;
         built_a_ff <= ATOM_LOG_MIN;
      end else begin
         if (csr_valid) begin
            unique case (csr_index)
               CSR_POOL_BLOCKS: pool_ff <= csr_data;
               CSR_ATOM_LOG:    alog_ff <= csr_data[LOG_W-1:0];
               default: ;
            endcase
         end
         if (cmd.op == CMD_CLR) begin
            built_n_ff <= (pool_ff > LINK_W'(NUM_BLOCKS)) ? LINK_W'(NUM_BLOCKS) : pool_ff;
            priority if (alog_ff < ATOM_LOG_MIN) built_a_ff <= ATOM_LOG_MIN;
            else if (alog_ff > ATOM_LOG_MAX)     built_a_ff <= ATOM_LOG_MAX;
            else                                 built_a_ff <= alog_ff;
         end
      end
   end

   // Working registers.
   always_ff @(posedge clock) begin
      unique case (cmd.op)
         CMD_LOAD: begin
            req_ff     <= req_payload.request_bytes;
            dec_ff     <= req_payload.request_bytes - REQ_W'(1);
            idx_ff     <= req_payload.free_index;
            clr_cnt_ff <= '0;
            off_ff     <= '0;
            bin_ff     <= LOG_W'(MAX_LOG);
         end
         CMD_ALOG: lg_ff <= lg_calc[LOG_W-1:0];
         CMD_ABIN: begin
            bin_ff   <= bin_sel;
            idx_ff   <= heads_ff[bin_sel][IDX_W-1:0];
            rm_lg_ff <= bin_sel;
         end
         CMD_SPLIT: bin_ff <= split_b;
         CMD_FCHK:  lg_ff <= fl;
         CMD_MRD:   rm_lg_ff <= lg_ff;
         CMD_MCHK: begin
            if (stat.merge_match) begin
               if (upper) idx_ff <= bud[IDX_W-1:0];
               lg_ff <= lg_ff + LOG_W'(1);
            end
         end
         CMD_CLR: clr_cnt_ff <= clr_cnt_ff + IDX_W'(1);
         CMD_CARVE: begin
            if (carve_fits) off_ff <= off_ff + carve_sz;
            bin_ff <= bin_ff - LOG_W'(1);
         end
         default: ;
      endcase
   end

   // Result register; fields are zero unless the item succeeded with a block.
   assign keep = (cmd.st == ST_OK) && cmd.keep;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.op == CMD_FIN) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
      if (cmd.op == CMD_FIN) begin
         rsp_ff.status        <= cmd.st;
         rsp_ff.granted_index <= keep ? idx_ff : '0;
         rsp_ff.granted_log   <= keep ? lg_ff : '0;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   // Checks on the datapath.
   `BBA_ASSERT_NOW(a_bin_in_pool, cmd.op == CMD_ABIN && found, heads_ff[bin_sel] < built_n_ff, "list head outside the pool")
   `BBA_ASSERT_NOW(a_split_above, cmd.op == CMD_SPLIT, bin_ff > lg_ff, "split below the wanted class")
   `BBA_ASSERT_NEXT(a_fail_zero, cmd.op == CMD_FIN && cmd.st != ST_OK, rsp_valid_ff && rsp_ff.granted_index == '0 && rsp_ff.granted_log == '0, "failed result carries a block")

endmodule

// File: test/buddy_block_allocator_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Buddy block allocator testbench
// Drives allocate, free, rebuild and ignored-action beats through several pool settings. A
// built-in buddy model predicts every response, and a monitor checks each one.
// ----------------------------------------------------------------------------
module buddy_block_allocator_test;
   import bba_pkg::*;

   localparam int HEAD_BIT  = 8'h40;
   localparam int FREE_BIT  = 8'h20;
   localparam int SIZE_MASK = 8'h1f;
   localparam logic [1:0] ACT_IGNORED = 2'd3;
   localparam int STALL_LIMIT = 20000;
   localparam int SETTLE_CYCLES = 60;

   logic             clock = 1'b0;
   logic             reset = 1'b1;
   logic             req_valid = 1'b0;
   logic             req_ready;
   req_type          req_payload = '0;
   logic             rsp_valid;
   logic             rsp_ready = 1'b0;
   rsp_type          rsp_payload;
   logic             csr_valid = 1'b0;
   logic             csr_ready;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_data = '0;

   buddy_block_allocator u_dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_payload(req_payload),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_payload(rsp_payload),
      .csr_valid(csr_valid), .csr_ready(csr_ready),
      .csr_index(csr_index), .csr_data(csr_data)
   );

   always #1 clock = ~clock;

   // Shadow allocator state.
   int unsigned atom_ctrl [NUM_BLOCKS];
   int          next_link [NUM_BLOCKS];
   int          prev_link [NUM_BLOCKS];
   int          class_head [MAX_LOG+1];
   int unsigned pool_reg, atom_reg, built_pool, built_atom;

   req_type pending_beats [$];
   rsp_type expected_rsps [$];
   int      live_blocks [$];
   int      fail_count = 0;
   int      send_idle = 0, recv_idle = 0;
   bit      req_fire = 0;
   bit      pressure_go = 0, pressure_done = 0;
   int      hold_left = 0;
   int      quiet_cycles = 0;

   function automatic void unlink(int i, int lg);
      int nx, pv;
      nx = next_link[i];
      pv = prev_link[i];
      if (pv < 0) class_head[lg] = nx;
      else next_link[pv] = nx;
      if (nx >= 0) prev_link[nx] = pv;
      next_link[i] = -1;
      prev_link[i] = -1;
   endfunction

   function automatic void link_front(int i, int lg);
      next_link[i] = class_head[lg];
      prev_link[i] = -1;
      if (class_head[lg] >= 0) prev_link[class_head[lg]] = i;
      class_head[lg] = i;
   endfunction

   function automatic void clear_shadow();
      for (int i = 0; i < NUM_BLOCKS; i++) begin
         atom_ctrl[i] = 0;
         next_link[i] = -1;
         prev_link[i] = -1;
      end
      for (int k = 0; k <= MAX_LOG; k++) class_head[k] = -1;
   endfunction

   function automatic void carve_pool();
      int unsigned off;
      off = 0;
      built_pool = (pool_reg > NUM_BLOCKS) ? NUM_BLOCKS : pool_reg;
      built_atom = (atom_reg < 3) ? 3 : (atom_reg > 12) ? 12 : atom_reg;
      clear_shadow();
      for (int lg = MAX_LOG; lg >= 0; lg--) begin
         while (off + (1 << lg) <= built_pool) begin
            atom_ctrl[off] = HEAD_BIT | FREE_BIT | lg;
            link_front(off, lg);
            off += 1 << lg;
         end
      end
   endfunction

   // Allocate: round up, find the smallest nonempty class, split it down.
   function automatic rsp_type predict_alloc(logic [REQ_W-1:0] nbytes);
      rsp_type r;
      longint  full;
      int      lg, bin, i;
      r = '0;
      if (nbytes == 0 || nbytes > BIG_REQUEST) begin
         r.status = ST_BADREQ;
         return r;
      end
      full = longint'(1) << built_atom;
      lg = 0;
      while (full < longint'(nbytes)) begin
         full = full << 1;
         lg++;
      end
      r.status = ST_NOSPACE;
      if (lg > MAX_LOG) return r;
      bin = lg;
      while (bin <= MAX_LOG && (class_head[bin] < 0 || class_head[bin] >= built_pool))
         bin++;
      if (bin > MAX_LOG) return r;
      i = class_head[bin];
      unlink(i, bin);
      while (bin > lg) begin
         bin--;
         if (i + (1 << bin) < NUM_BLOCKS) begin
            atom_ctrl[i + (1 << bin)] = HEAD_BIT | FREE_BIT | bin;
            link_front(i + (1 << bin), bin);
         end
      end
      atom_ctrl[i] = HEAD_BIT | lg;
      r.status = ST_OK;
      r.granted_index = i[IDX_W-1:0];
      r.granted_log = lg[LOG_W-1:0];
      return r;
   endfunction

   // Free: validate the block, then merge with free buddies upward.
   function automatic rsp_type predict_free(int blk);
      rsp_type     r;
      int unsigned c, lg, size;
      int          bud;
      r = '0;
      r.status = ST_BADFREE;
      if (blk >= built_pool) return r;
      c = atom_ctrl[blk];
      if ((c & HEAD_BIT) == 0 || (c & FREE_BIT) != 0) return r;
      lg = c & SIZE_MASK;
      if (lg > MAX_LOG) return r;
      size = 1 << lg;
      if ((blk & (size - 1)) != 0 || blk + size > built_pool) return r;
      atom_ctrl[blk] = HEAD_BIT | FREE_BIT | lg;
      while (lg < MAX_LOG) begin
         if ((blk >> lg) & 1) begin
            bud = blk - size;
         end else begin
            bud = blk + size;
            if (bud >= built_pool) break;
         end
         if (bud >= NUM_BLOCKS || atom_ctrl[bud] != (HEAD_BIT | FREE_BIT | lg)) break;
         unlink(bud, lg);
         lg++;
         if (bud < blk) begin
            atom_ctrl[blk] = 0;
            blk = bud;
         end else begin
            atom_ctrl[bud] = 0;
         end
         atom_ctrl[blk] = HEAD_BIT | FREE_BIT | lg;
         size = size << 1;
      end
      link_front(blk, lg);
      r.status = ST_OK;
      r.granted_index = blk[IDX_W-1:0];
      r.granted_log = lg[LOG_W-1:0];
      return r;
   endfunction

   // Queue one request beat and, for a known action, its predicted response.
   task automatic issue(logic [1:0] act, logic [REQ_W-1:0] nbytes, int idx);
      req_type b;
      rsp_type r;
      b.action = act;
      b.request_bytes = nbytes;
      b.free_index = idx[IDX_W-1:0];
      pending_beats.push_back(b);
      r = '0;
      case (act)
         ACT_ALLOC: begin
            r = predict_alloc(nbytes);
            if (r.status == ST_OK) live_blocks.push_back(r.granted_index);
         end
         ACT_FREE: begin
            r = predict_free(idx);
         end
         ACT_REBUILD: begin
            carve_pool();
            live_blocks.delete();
         end
         default: return;
      endcase
      expected_rsps.push_back(r);
   endtask

   task automatic wait_idle();
      while (pending_beats.size() != 0 || expected_rsps.size() != 0 || req_valid)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_csr(logic [CSR_IDX_W-1:0] idx, int unsigned value);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= value[CSR_DATA_W-1:0];
      do @(posedge clock); while (!csr_ready);
      if (idx == CSR_POOL_BLOCKS) pool_reg = value & 11'h7ff;
      else atom_reg = value & 4'hf;
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // Mostly realistic sizes, sometimes any 31-bit value.
   function automatic logic [REQ_W-1:0] pick_bytes();
      int lg;
      if ($urandom_range(0, 99) < 12) return REQ_W'($urandom());
      lg = ($urandom_range(0, 3) == 0) ? $urandom_range(0, MAX_LOG) : $urandom_range(0, 3);
      return REQ_W'($urandom_range(1, 1 << (built_atom + lg)));
   endfunction

   task automatic random_items(int count);
      int r, k;
      for (int n = 0; n < count; n++) begin
         r = $urandom_range(0, 99);
         if (r < 52) begin
            issue(ACT_ALLOC, pick_bytes(), $urandom_range(0, 1023));
         end else if (r < 85 && live_blocks.size() != 0) begin
            k = $urandom_range(0, live_blocks.size() - 1);
            issue(ACT_FREE, REQ_W'($urandom()), live_blocks[k]);
            live_blocks.delete(k);
         end else if (r < 96) begin
            issue(ACT_FREE, REQ_W'($urandom()), $urandom_range(0, 1023));
         end else if (r < 98) begin
            issue(ACT_REBUILD, REQ_W'($urandom()), $urandom_range(0, 1023));
         end else begin
            issue(ACT_IGNORED, REQ_W'($urandom()), $urandom_range(0, 1023));
         end
      end
   endtask

   // Main sequence: reset, directed checks, then one random phase per setting.
   initial begin
      int pool_set [6] = '{1024, 0, 1, 2047, 700, 37};
      int atom_set [6] = '{3, 5, 12, 15, 0, 4};
      pool_reg = 1024;
      atom_reg = 3;
      built_pool = 0;
      built_atom = 3;
      clear_shadow();
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      send_idle = 8;
      recv_idle = 81;

      // Nothing is built yet, so allocates and frees fail.
      issue(ACT_ALLOC, 1, 0);
      issue(ACT_FREE, 0, 0);
      wait_idle();
      write_csr(CSR_POOL_BLOCKS, 1024);
      write_csr(CSR_ATOM_LOG, 3);

      // Request limits, a whole-pool block, exhaustion, bad and merging frees.
      issue(ACT_REBUILD, 0, 0);
      issue(ACT_ALLOC, 0, 0);
      issue(ACT_ALLOC, 31'h4000_0001, 0);
      issue(ACT_ALLOC, 31'h7fff_ffff, 1023);
      issue(ACT_ALLOC, 31'h4000_0000, 0);
      issue(ACT_ALLOC, 8192, 0);
      issue(ACT_ALLOC, 1, 0);
      issue(ACT_FREE, 0, 1023);
      issue(ACT_FREE, 0, 0);
      issue(ACT_FREE, 0, 0);
      issue(ACT_ALLOC, 16, 0);
      issue(ACT_FREE, 0, 1);
      issue(ACT_IGNORED, 31'h7fff_ffff, 1023);
      issue(ACT_ALLOC, 8, 0);
      issue(ACT_ALLOC, 9, 0);
      issue(ACT_FREE, 0, 2);
      issue(ACT_FREE, 0, 0);
      issue(ACT_FREE, 0, 4);
      pressure_go = 1;
      live_blocks.delete();
      random_items(40);
      wait_idle();

      for (int p = 0; p < 6; p++) begin
         send_idle = (p < 2) ? 8 : (p < 4) ? 81 : 0;
         recv_idle = (p < 2) ? 81 : (p < 4) ? 8 : 0;
         write_csr(CSR_POOL_BLOCKS, pool_set[p]);
         write_csr(CSR_ATOM_LOG, atom_set[p]);
         issue(ACT_REBUILD, REQ_W'($urandom()), $urandom_range(0, 1023));
         random_items(60);
         wait_idle();
      end

      if (fail_count == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

   // Request driver: hold a beat until it is taken, then offer the next.
   always @(posedge clock) begin
      req_fire <= req_valid && req_ready;
   end

   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (req_valid && !req_fire) begin
         req_valid <= 1'b1;
      end else if (pending_beats.size() != 0 && $urandom_range(0, 99) >= send_idle) begin
         req_payload <= pending_beats.pop_front();
         req_valid <= 1'b1;
      end else begin
         req_valid <= 1'b0;
      end
   end

   // Response ready, with one long hold-off so the block backs up.
   always @(negedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else if (pressure_go && !pressure_done) begin
         pressure_done <= 1'b1;
         hold_left <= 400;
         rsp_ready <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left <= hold_left - 1;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(0, 99) >= recv_idle);
      end
   end

   // Response monitor: compare each beat against the oldest prediction.
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_rsps.size() == 0) begin
            $display("%0t: unexpected response %p", $time, rsp_payload);
            fail_count++;
         end else begin
            rsp_type want;
            want = expected_rsps.pop_front();
            if (rsp_payload.status !== want.status)
               $display("%0t: status expected %0d actual %0d",
                        $time, want.status, rsp_payload.status);
            if (rsp_payload.granted_index !== want.granted_index)
               $display("%0t: granted_index expected %0d actual %0d",
                        $time, want.granted_index, rsp_payload.granted_index);
            if (rsp_payload.granted_log !== want.granted_log)
               $display("%0t: granted_log expected %0d actual %0d",
                        $time, want.granted_log, rsp_payload.granted_log);
            if (rsp_payload !== want) fail_count++;
         end
      end
   end

   // Watchdog on cycles with no beat moving on any channel.
   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || (csr_valid && csr_ready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
         $display("%0t: no progress, %0d responses outstanding", $time, expected_rsps.size());
         $display("*** FAILED ***");
         $finish;
      end
   end

endmodule

// File: filelist.f
+incdir+rtl
rtl/bba_pkg.sv
rtl/bba_ctrl.sv
rtl/bba_dpath.sv
rtl/buddy_block_allocator.sv
test/buddy_block_allocator_test.sv
